// File: hdl/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// Holds the word structs, character codes, status and digit-class codes.
// No dependencies.
package ilp_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
    } t_out_word;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FLOAT    = 3'd1;
    localparam logic [2:0] ST_BAD_BASE = 3'd2;
    localparam logic [2:0] ST_NO_DIGIT = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_INVALID  = 3'd5;
    localparam logic [2:0] ST_TOO_BIG  = 3'd6;

    localparam logic [1:0] DE_NONE    = 2'd0;
    localparam logic [1:0] DE_INVALID = 2'd1;
    localparam logic [1:0] DE_TOO_BIG = 2'd2;

    localparam logic [4:0] RADIX_2  = 5'd2;
    localparam logic [4:0] RADIX_8  = 5'd8;
    localparam logic [4:0] RADIX_10 = 5'd10;
    localparam logic [4:0] RADIX_16 = 5'd16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    typedef struct packed {
        logic [1:0] err;
        logic [3:0] digit;
    } t_digit_class;

endpackage

// File: hdl/ilp_digit.sv
// Digit classifier: maps one character to a digit value or an error class.
// Depends on ilp_pkg.
module ilp_digit (
    input  logic [7:0]            i_char,
    input  logic [4:0]            i_radix,
    output ilp_pkg::t_digit_class o_class
);
    import ilp_pkg::*;

    logic [7:0] w_val;
    logic       w_ok;

    always_comb begin
        w_val = 8'd0;
        w_ok  = 1'b1;
        if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
            w_val = i_char - CH_ZERO;
        end else if (i_radix == RADIX_16 && i_char >= CH_LO_A && i_char <= CH_LO_F) begin
            w_val = i_char - CH_LO_A + 8'd10;
        end else if (i_radix == RADIX_16 && i_char >= CH_UP_A && i_char <= CH_UP_F) begin
            w_val = i_char - CH_UP_A + 8'd10;
        end else begin
            w_ok = 1'b0;
        end
        o_class.digit = w_val[3:0];
        if (!w_ok) begin
            o_class.err = DE_INVALID;
        end else if (w_val >= {3'd0, i_radix}) begin
            o_class.err = DE_TOO_BIG;
        end else begin
            o_class.err = DE_NONE;
        end
    end

endmodule

// File: hdl/ilp_accum.sv
// Literal state and accumulator: prefix detection, digit count, error flags.
// Builds the result word on the final character. Depends on ilp_pkg, ilp_digit.
module ilp_accum #(
    parameter int MAX_DIGITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  ilp_pkg::t_in_word  i_word,
    output ilp_pkg::t_out_word o_result
);
    import ilp_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 2);
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_DIGITS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

    logic [1:0]    r_pos,   n_pos;
    logic          r_fwz,   n_fwz;
    logic [4:0]    r_radix, n_radix;
    logic [63:0]   r_acc,   n_acc;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic          r_dot,   n_dot;
    logic          r_perr,  n_perr;
    logic [1:0]    r_derr,  n_derr;

    t_digit_class w_class;
    logic [63:0]  w_scaled;
    logic [7:0]   w_c;

    assign w_c = i_word.character;

    ilp_digit u_digit (
        .i_char  (w_c),
        .i_radix (r_radix),
        .o_class (w_class)
    );

    always_comb begin
        unique case (r_radix)
            RADIX_16: w_scaled = {r_acc[59:0], 4'd0};
            RADIX_8:  w_scaled = {r_acc[60:0], 3'd0};
            RADIX_2:  w_scaled = {r_acc[62:0], 1'b0};
            default:  w_scaled = {r_acc[60:0], 3'd0} + {r_acc[62:0], 1'b0};
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_fwz   = r_fwz;
        n_radix = r_radix;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_dot   = r_dot | (w_c == CH_DOT);
        n_perr  = r_perr;
        n_derr  = r_derr;
        if (r_pos == 2'd1 && r_fwz) begin
            if (w_c == CH_X || w_c == CH_O || w_c == CH_B) begin
                n_radix = (w_c == CH_X) ? RADIX_16 : (w_c == CH_O) ? RADIX_8 : RADIX_2;
                n_acc   = 64'd0;
                n_cnt   = '0;
                n_derr  = DE_NONE;
            end else begin
                n_perr = 1'b1;
            end
        end else begin
            if (r_cnt < CNT_SAT) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (w_class.err != DE_NONE) begin
                n_derr = w_class.err;
            end else begin
                n_acc = w_scaled + {60'd0, w_class.digit};
            end
        end
        if (r_pos == 2'd0) begin
            n_fwz = (w_c == CH_ZERO);
        end
        if (r_pos != 2'd2) begin
            n_pos = r_pos + 2'd1;
        end
    end

    always_comb begin
        priority if (n_dot) begin
            o_result.status = ST_FLOAT;
        end else if (n_perr) begin
            o_result.status = ST_BAD_BASE;
        end else if (n_radix != RADIX_10 && n_cnt == '0) begin
            o_result.status = ST_NO_DIGIT;
        end else if (n_cnt > CNT_MAX) begin
            o_result.status = ST_TOO_LONG;
        end else if (n_derr == DE_INVALID) begin
            o_result.status = ST_INVALID;
        end else if (n_derr == DE_TOO_BIG) begin
            o_result.status = ST_TOO_BIG;
        end else begin
            o_result.status = ST_OK;
        end
        o_result.value = (o_result.status == ST_OK) ? n_acc : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last_char)) begin
            r_pos   <= 2'd0;
            r_fwz   <= 1'b0;
            r_radix <= RADIX_10;
            r_acc   <= 64'd0;
            r_cnt   <= '0;
            r_dot   <= 1'b0;
            r_perr  <= 1'b0;
            r_derr  <= DE_NONE;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_fwz   <= n_fwz;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_dot   <= n_dot;
            r_perr  <= n_perr;
            r_derr  <= n_derr;
        end
    end

endmodule

// File: hdl/integer_literal_parser.sv
// Top level of the integer literal parser: input register, state update, result register.
// Depends on ilp_pkg and ilp_accum.
//
//  channel | direction | handshake              | word
//  in      | input     | i_in_valid, o_in_stall  | i_in_word  (character, last_char)
//  out     | output    | o_out_valid, i_out_stall| o_out_word (value, status)
//
// One character per cycle unless a final character stalls behind a blocked result.
// The 64-bit shift-add of the accumulator sets the cycle time.
// Synchronous active-low reset clears both valid flags and all literal state.
// A stalled result blocks only a final character; other characters keep flowing.
module integer_literal_parser #(
    parameter int MAX_DIGITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ilp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ilp_pkg::t_out_word o_out_word
);
    import ilp_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    logic      w_out_free;
    logic      w_step;
    logic      w_emit;
    t_out_word w_result;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && (!r_in.last_char || w_out_free);
    assign w_emit      = w_step && r_in.last_char;
    assign o_in_stall  = r_in_valid && !w_step;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    ilp_accum #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_OK) |-> o_out_word.value == 64'd0)
        else $error("nonzero value with error status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.status <= ST_TOO_BIG)
        else $error("status code out of range");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out_valid)
        else $error("final character gave no result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in.last_char && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule
